/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/u8d_pkg.sv */
// Shared widths, status codes and result word type for the UTF-8 decoder.
// No dependencies.
package u8d_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REM_W    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic [REM_W-1:0] more;
    logic [4:0]       bits;
  } lead_t;

endpackage

/* rtl/u8d_in_if.sv */
// Byte input channel: valid/ready handshake with one byte or an end marker.
// Depends on u8d_pkg.
interface u8d_in_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::BYTE_W-1:0]   data_byte;
  logic                         end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

/* rtl/u8d_out_if.sv */
// Result channel: valid/ready handshake carrying one decoded word.
// Depends on u8d_pkg.
interface u8d_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::CP_W-1:0]     code_point;
  logic [u8d_pkg::STATUS_W-1:0] status;
  logic                         last_of_run;

  modport source (output valid, output code_point, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input status, input last_of_run,
                  output ready);
endinterface

/* rtl/utf8_stream_decoder.sv */
// An accepted byte is held in the input register, then decoded into the output queue.
// Throughput: one byte per cycle while the output queue has room; a byte that yields
// two words waits for an empty output queue.
// The two-entry output queue sets the rate; its count and the byte's word count gate decode.
// Reset clears the pending sequence, raw mode, the input register and the queue.
module utf8_stream_decoder (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  u8d_in_if.sink    byte_in,
  u8d_out_if.source char_out
);
  import u8d_pkg::*;

  function automatic lead_t lead_decode(input logic [BYTE_W-1:0] b);
    lead_t l;
    l = '0;
    priority if (b[7:5] == 3'b110) begin
      l.more = 3'd1;
      l.bits = b[4:0];
    end else if (b[7:4] == 4'b1110) begin
      l.more = 3'd2;
      l.bits = {1'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      l.more = 3'd3;
      l.bits = {2'b0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      l.more = 3'd4;
      l.bits = {3'b0, b[1:0]};
    end else begin
      l.more = 3'd5;
      l.bits = {4'b0, b[0]};
    end
    return l;
  endfunction

  // configuration and decoder state
  logic              raw_byte_mode;
  logic [REM_W-1:0]  bytes_remaining, bytes_remaining_next;
  logic [CP_W-1:0]   partial_value, partial_value_next;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eoi;

  // output queue
  result_t           fifo [2];
  logic              head;
  logic [1:0]        count;

  result_t           r0, r1, f_res;
  logic [1:0]        n_res;
  logic              f_has;
  logic [REM_W-1:0]  f_rem;
  logic [CP_W-1:0]   f_part, shifted;
  lead_t             lead;
  logic              fire, pop, wr0;
  logic [2:0]        total;

  // decode of a byte as a fresh start (nothing pending, or after a broken sequence)
  always_comb begin
    lead   = lead_decode(in_byte);
    f_has  = 1'b0;
    f_res  = '{code_point: '0, status: ST_VALID, last_of_run: 1'b0};
    f_rem  = '0;
    f_part = '0;
    if (!in_byte[7]) begin
      f_has            = 1'b1;
      f_res.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
    end else if (in_byte[7:6] == 2'b10 || in_byte[7:1] == 7'b1111111) begin
      f_has        = 1'b1;
      f_res.status = ST_INVALID;
    end else begin
      f_rem  = lead.more;
      f_part = {{(CP_W-5){1'b0}}, lead.bits};
    end
  end

  assign shifted = {partial_value[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    n_res                = 2'd0;
    r0                   = '{code_point: '0, status: ST_VALID, last_of_run: 1'b0};
    r1                   = '{code_point: '0, status: ST_END, last_of_run: 1'b0};
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;
    if (raw_byte_mode) begin
      bytes_remaining_next = '0;
      partial_value_next   = '0;
      n_res                = 2'd1;
      if (in_eoi) begin
        r0.status = ST_END;
      end else begin
        r0.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
      end
    end else if (in_eoi) begin
      bytes_remaining_next = '0;
      partial_value_next   = '0;
      if (bytes_remaining != '0) begin
        n_res     = 2'd2;
        r0.status = ST_INVALID;
      end else begin
        n_res     = 2'd1;
        r0.status = ST_END;
      end
    end else if (bytes_remaining != '0) begin
      if (in_byte[7:6] == 2'b10) begin
        bytes_remaining_next = bytes_remaining - 3'd1;
        if (bytes_remaining == 3'd1) begin
          n_res              = 2'd1;
          r0.code_point      = shifted;
          partial_value_next = '0;
        end else begin
          partial_value_next = shifted;
        end
      end else begin
        // broken sequence: flag it, then treat the byte as fresh
        r0.status            = ST_INVALID;
        bytes_remaining_next = f_rem;
        partial_value_next   = f_part;
        if (f_has) begin
          n_res = 2'd2;
          r1    = f_res;
        end else begin
          n_res = 2'd1;
        end
      end
    end else begin
      bytes_remaining_next = f_rem;
      partial_value_next   = f_part;
      if (f_has) begin
        n_res = 2'd1;
        r0    = f_res;
      end
    end
    r0.last_of_run = (n_res == 2'd1);
    r1.last_of_run = 1'b1;
  end

  // gate on queue occupancy only, so output ready never reaches input ready
  assign total         = {1'b0, count} + {1'b0, n_res};
  assign fire          = in_valid && (total <= 3'd2);
  assign byte_in.ready = !in_valid || fire;
  assign pop           = char_out.valid && char_out.ready;
  assign wr0           = head ^ count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_byte_mode   <= 1'b0;
      bytes_remaining <= '0;
      partial_value   <= '0;
      in_valid        <= 1'b0;
      head            <= 1'b0;
      count           <= '0;
    end else begin
      if (cfg_wr_en) begin
        raw_byte_mode <= cfg_wr_data;
      end
      if (byte_in.ready) begin
        in_valid <= byte_in.valid;
      end
      if (fire) begin
        bytes_remaining <= bytes_remaining_next;
        partial_value   <= partial_value_next;
      end
      head  <= head ^ pop;
      count <= count + (fire ? n_res : 2'd0) - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.data_byte;
      in_eoi  <= byte_in.end_of_input;
    end
    if (fire && n_res != 2'd0) begin
      fifo[wr0] <= r0;
    end
    if (fire && n_res == 2'd2) begin
      fifo[~wr0] <= r1;
    end
  end

  assign char_out.valid       = (count != '0);
  assign char_out.code_point  = fifo[head].code_point;
  assign char_out.status      = fifo[head].status;
  assign char_out.last_of_run = fifo[head].last_of_run;

  `include "assert_macros.svh"

  `ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, count <= 2'd2)
  `ASSERT_IMP(a_rem_bound, clk, rst, 1'b1, bytes_remaining <= 3'd5)
  `ASSERT_IMP(a_pair_needs_empty, clk, rst, fire && n_res == 2'd2, count == 2'd0)
  `ASSERT_NXT(a_raw_clears, clk, rst, fire && raw_byte_mode, bytes_remaining == 3'd0)

endmodule
